[sv/rgbled_pkg.sv]
// rgbled_pkg: request codes, power and animation types, gamma table and
// shared constants for the rgb led effect controller
// no dependencies
package rgbled_pkg;

  typedef enum logic [3:0] {
    REQ_ENABLE     = 4'd0,
    REQ_DISABLE    = 4'd1,
    REQ_ON         = 4'd2,
    REQ_OFF        = 4'd3,
    REQ_BRIGHTNESS = 4'd4,
    REQ_COLOR      = 4'd5,
    REQ_PULSE      = 4'd6,
    REQ_RAINBOW    = 4'd7,
    REQ_TICK       = 4'd8
  } req_t;

  typedef enum logic [2:0] {
    PWR_DISABLED = 3'b001,
    PWR_OFF      = 3'b010,
    PWR_ON       = 3'b100
  } pwr_t;

  typedef enum logic [2:0] {
    FX_NONE    = 3'b001,
    FX_PULSE   = 3'b010,
    FX_RAINBOW = 3'b100
  } fx_t;

  localparam logic [1:0] MODE_DISABLED = 2'd0;
  localparam logic [1:0] MODE_OFF      = 2'd1;
  localparam logic [1:0] MODE_ON       = 2'd2;

  localparam int unsigned PULSE_STEPS   = 32'h200;
  localparam int unsigned RAINBOW_STEPS = 32'h600;
  localparam int unsigned PULSE_BITS    = $clog2(PULSE_STEPS);
  localparam int unsigned RAINBOW_BITS  = $clog2(RAINBOW_STEPS);

  localparam logic [23:0] RAINBOW_START = 24'hff0000;
  localparam logic [7:0]  FULL_BRIGHT   = 8'hff;

  // what the level stage needs from the controller state
  typedef struct packed {
    pwr_t        power;
    logic [23:0] color;
    logic [7:0]  brightness;
  } led_view_t;

  // 8-bit gamma curve close to 255 * (x/255)^2.2
  localparam logic [7:0] GAMMA_TAB [256] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,
    8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,
    8'd2,   8'd2,   8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
    8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,   8'd5,
    8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,   8'd8,   8'd8,
    8'd8,   8'd9,   8'd9,   8'd9,   8'd10,  8'd10,  8'd11,  8'd11,
    8'd11,  8'd12,  8'd12,  8'd13,  8'd13,  8'd13,  8'd14,  8'd14,
    8'd15,  8'd15,  8'd16,  8'd16,  8'd17,  8'd17,  8'd18,  8'd18,
    8'd19,  8'd19,  8'd20,  8'd21,  8'd21,  8'd22,  8'd22,  8'd23,
    8'd23,  8'd24,  8'd25,  8'd25,  8'd26,  8'd27,  8'd27,  8'd28,
    8'd29,  8'd29,  8'd30,  8'd31,  8'd31,  8'd32,  8'd33,  8'd34,
    8'd34,  8'd35,  8'd36,  8'd37,  8'd37,  8'd38,  8'd39,  8'd40,
    8'd40,  8'd41,  8'd42,  8'd43,  8'd44,  8'd45,  8'd46,  8'd46,
    8'd47,  8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,
    8'd55,  8'd56,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,
    8'd63,  8'd64,  8'd65,  8'd66,  8'd67,  8'd68,  8'd69,  8'd70,
    8'd71,  8'd72,  8'd73,  8'd74,  8'd76,  8'd77,  8'd78,  8'd79,
    8'd80,  8'd81,  8'd83,  8'd84,  8'd85,  8'd86,  8'd88,  8'd89,
    8'd90,  8'd91,  8'd93,  8'd94,  8'd95,  8'd96,  8'd98,  8'd99,
    8'd100, 8'd102, 8'd103, 8'd104, 8'd106, 8'd107, 8'd109, 8'd110,
    8'd111, 8'd113, 8'd114, 8'd116, 8'd117, 8'd119, 8'd120, 8'd121,
    8'd123, 8'd124, 8'd126, 8'd128, 8'd129, 8'd131, 8'd132, 8'd134,
    8'd135, 8'd137, 8'd138, 8'd140, 8'd142, 8'd143, 8'd145, 8'd146,
    8'd148, 8'd150, 8'd151, 8'd153, 8'd155, 8'd157, 8'd158, 8'd160,
    8'd162, 8'd163, 8'd165, 8'd167, 8'd169, 8'd170, 8'd172, 8'd174,
    8'd176, 8'd178, 8'd179, 8'd181, 8'd183, 8'd185, 8'd187, 8'd189,
    8'd191, 8'd193, 8'd194, 8'd196, 8'd198, 8'd200, 8'd202, 8'd204,
    8'd206, 8'd208, 8'd210, 8'd212, 8'd214, 8'd216, 8'd218, 8'd220,
    8'd222, 8'd224, 8'd227, 8'd229, 8'd231, 8'd233, 8'd235, 8'd237,
    8'd239, 8'd241, 8'd244, 8'd246, 8'd248, 8'd250, 8'd252, 8'd255
  };

  function automatic logic [1:0] pwr_code(input pwr_t p);
    logic [1:0] c;
    case (p)
      PWR_ON:  c = MODE_ON;
      PWR_OFF: c = MODE_OFF;
      default: c = MODE_DISABLED;
    endcase
    return c;
  endfunction

endpackage

[sv/rgb_led_effect_controller_unit.sv]
// rgb_led_effect_controller_unit: top level, request handshake, state update
// and registered result stage
// depends on rgbled_pkg, rgbled_state, rgbled_level
//
//   channel | direction | ports
//   --------+-----------+----------------------------------------------------
//   in      | input     | in_valid/in_ready, in_req_type, in_value, in_interval
//   out     | output    | out_valid/out_ready, out_{red,green,blue}_level,
//           |           | out_power_mode
//
// one request per cycle sustained while out_ready stays high; a request's result
// passes through the state registers, which take the update at acceptance,
// then the output register, fed by the gamma lookup and 8x8 multiply per channel
// synchronous active-low reset clears state to disabled, no animation, zeros
// a stalled output holds its result; one more request is taken and parked in
// the state registers, then in_ready drops until the output frees
module rgb_led_effect_controller_unit #(
  parameter int unsigned INTERVAL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_req_type,
  input  logic [23:0] in_value,
  input  logic [15:0] in_interval,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_red_level,
  output logic [15:0] out_green_level,
  output logic [15:0] out_blue_level,
  output logic [1:0]  out_power_mode
);

  rgbled_pkg::led_view_t view;
  logic        in_fire;
  logic        st_valid_r;
  logic        st_adv;
  logic        pwr_on;
  logic [15:0] red_lvl, green_lvl, blue_lvl;
  logic        out_valid_r;
  logic [15:0] red_r, green_r, blue_r;
  logic [1:0]  mode_r;

  // state registers double as the first stage: hold while a result waits
  assign st_adv   = st_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !st_valid_r || st_adv;
  assign in_fire  = in_valid && in_ready;

  rgbled_state #(
    .INTERVAL_BITS(INTERVAL_BITS)
  ) u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (in_fire),
    .req_type (in_req_type),
    .value    (in_value),
    .interval (in_interval),
    .view     (view)
  );

  assign pwr_on = (view.power == rgbled_pkg::PWR_ON);

  rgbled_level u_red (
    .on         (pwr_on),
    .component  (view.color[23:16]),
    .brightness (view.brightness),
    .level      (red_lvl)
  );

  rgbled_level u_green (
    .on         (pwr_on),
    .component  (view.color[15:8]),
    .brightness (view.brightness),
    .level      (green_lvl)
  );

  rgbled_level u_blue (
    .on         (pwr_on),
    .component  (view.color[7:0]),
    .brightness (view.brightness),
    .level      (blue_lvl)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        st_valid_r <= 1'b1;
      end else if (st_adv) begin
        st_valid_r <= 1'b0;
      end
      if (st_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_adv) begin
      red_r   <= red_lvl;
      green_r <= green_lvl;
      blue_r  <= blue_lvl;
      mode_r  <= rgbled_pkg::pwr_code(view.power);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red_level   = red_r;
  assign out_green_level = green_r;
  assign out_blue_level  = blue_r;
  assign out_power_mode  = mode_r;

endmodule

[sv/rgbled_state.sv]
// rgbled_state: command decode and controller state registers (power, color,
// brightness, animation mode and step counters)
// depends on rgbled_pkg
module rgbled_state #(
  parameter int unsigned INTERVAL_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 upd,
  input  logic [3:0]           req_type,
  input  logic [23:0]          value,
  input  logic [15:0]          interval,
  output rgbled_pkg::led_view_t view
);

  rgbled_pkg::pwr_t power_r, power_nxt;
  rgbled_pkg::fx_t  fx_r, fx_nxt;
  logic [23:0] color_r, color_nxt;
  logic [7:0]  bright_r, bright_nxt;
  logic [rgbled_pkg::PULSE_BITS-1:0]   pulse_r, pulse_nxt;
  logic [rgbled_pkg::RAINBOW_BITS-1:0] rainbow_r, rainbow_nxt;
  logic [INTERVAL_BITS-1:0] ival_r, ival_nxt;
  logic [INTERVAL_BITS-1:0] tick_r, tick_nxt;

  logic [INTERVAL_BITS+15:0] ival_wide;
  logic [INTERVAL_BITS-1:0]  ival_in;
  logic [INTERVAL_BITS-1:0]  tick_inc;
  logic                      step_due;

  // pulse ramp
  logic [rgbled_pkg::PULSE_BITS:0] pulse_ramp;
  logic [7:0]                      pulse_bright;

  // rainbow hue wheel
  logic [rgbled_pkg::RAINBOW_BITS-1:0] rb_s;
  logic [rgbled_pkg::RAINBOW_BITS-1:0] rb_next;
  logic [7:0]                          rb_t;
  logic [23:0]                         rb_color;

  assign ival_wide = {{INTERVAL_BITS{1'b0}}, interval};
  assign ival_in   = ival_wide[INTERVAL_BITS-1:0];
  assign tick_inc  = tick_r + 1'b1;
  assign step_due  = (tick_inc >= ival_r) || (tick_inc == '0);

  always_comb begin
    if (pulse_r[rgbled_pkg::PULSE_BITS-1]) begin
      pulse_ramp = (rgbled_pkg::PULSE_BITS+1)'(rgbled_pkg::PULSE_STEPS) - {1'b0, pulse_r};
    end else begin
      pulse_ramp = {1'b0, pulse_r};
    end
    // the peak at half period saturates
    if (pulse_ramp > (rgbled_pkg::PULSE_BITS+1)'(rgbled_pkg::FULL_BRIGHT)) begin
      pulse_bright = rgbled_pkg::FULL_BRIGHT;
    end else begin
      pulse_bright = pulse_ramp[7:0];
    end
  end

  always_comb begin
    if (rainbow_r >= rgbled_pkg::RAINBOW_BITS'(rgbled_pkg::RAINBOW_STEPS)) begin
      rb_s = '0;
    end else begin
      rb_s = rainbow_r;
    end
    rb_t = rb_s[7:0];
    case (rb_s[rgbled_pkg::RAINBOW_BITS-1:8])
      3'd0:    rb_color = {8'hff, rb_t, 8'h00};
      3'd1:    rb_color = {8'hff - rb_t, 8'hff, 8'h00};
      3'd2:    rb_color = {8'h00, 8'hff, rb_t};
      3'd3:    rb_color = {8'h00, 8'hff - rb_t, 8'hff};
      3'd4:    rb_color = {rb_t, 8'h00, 8'hff};
      default: rb_color = {8'hff, 8'h00, 8'hff - rb_t};
    endcase
    if (rb_s == rgbled_pkg::RAINBOW_BITS'(rgbled_pkg::RAINBOW_STEPS - 1)) begin
      rb_next = '0;
    end else begin
      rb_next = rb_s + 1'b1;
    end
  end

  always_comb begin
    power_nxt   = power_r;
    fx_nxt      = fx_r;
    color_nxt   = color_r;
    bright_nxt  = bright_r;
    pulse_nxt   = pulse_r;
    rainbow_nxt = rainbow_r;
    ival_nxt    = ival_r;
    tick_nxt    = tick_r;
    case (req_type)
      rgbled_pkg::REQ_ENABLE:  power_nxt = rgbled_pkg::PWR_OFF;
      rgbled_pkg::REQ_DISABLE: power_nxt = rgbled_pkg::PWR_DISABLED;
      rgbled_pkg::REQ_ON: begin
        if (power_r == rgbled_pkg::PWR_OFF) power_nxt = rgbled_pkg::PWR_ON;
      end
      rgbled_pkg::REQ_OFF: begin
        if (power_r == rgbled_pkg::PWR_ON) power_nxt = rgbled_pkg::PWR_OFF;
      end
      rgbled_pkg::REQ_BRIGHTNESS: begin
        fx_nxt     = rgbled_pkg::FX_NONE;
        bright_nxt = value[7:0];
      end
      rgbled_pkg::REQ_COLOR: begin
        fx_nxt    = rgbled_pkg::FX_NONE;
        color_nxt = value;
      end
      rgbled_pkg::REQ_PULSE, rgbled_pkg::REQ_RAINBOW: begin
        // off and on both end up on, disabled stays disabled
        if (power_r != rgbled_pkg::PWR_DISABLED) power_nxt = rgbled_pkg::PWR_ON;
        if (req_type == rgbled_pkg::REQ_PULSE) begin
          fx_nxt     = rgbled_pkg::FX_PULSE;
          bright_nxt = '0;
          color_nxt  = value;
        end else begin
          fx_nxt     = rgbled_pkg::FX_RAINBOW;
          bright_nxt = rgbled_pkg::FULL_BRIGHT;
          color_nxt  = rgbled_pkg::RAINBOW_START;
        end
        ival_nxt = ival_in;
        tick_nxt = '0;
      end
      rgbled_pkg::REQ_TICK: begin
        if (fx_r != rgbled_pkg::FX_NONE) begin
          if (step_due) begin
            tick_nxt = '0;
            if (fx_r == rgbled_pkg::FX_PULSE) begin
              bright_nxt = pulse_bright;
              pulse_nxt  = pulse_r + 1'b1;
            end else begin
              color_nxt   = rb_color;
              rainbow_nxt = rb_next;
            end
          end else begin
            tick_nxt = tick_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_r   <= rgbled_pkg::PWR_DISABLED;
      fx_r      <= rgbled_pkg::FX_NONE;
      color_r   <= '0;
      bright_r  <= '0;
      pulse_r   <= '0;
      rainbow_r <= '0;
      ival_r    <= '0;
      tick_r    <= '0;
    end else if (upd) begin
      power_r   <= power_nxt;
      fx_r      <= fx_nxt;
      color_r   <= color_nxt;
      bright_r  <= bright_nxt;
      pulse_r   <= pulse_nxt;
      rainbow_r <= rainbow_nxt;
      ival_r    <= ival_nxt;
      tick_r    <= tick_nxt;
    end
  end

  assign view.power      = power_r;
  assign view.color      = color_r;
  assign view.brightness = bright_r;

endmodule

[sv/rgbled_level.sv]
// rgbled_level: one channel's drive level, gamma lookup times brightness,
// gated by power state
// depends on rgbled_pkg
module rgbled_level (
  input  logic       on,
  input  logic [7:0] component,
  input  logic [7:0] brightness,
  output logic [15:0] level
);

  logic [15:0] prod;

  assign prod  = 16'(rgbled_pkg::GAMMA_TAB[component]) * 16'(brightness);
  assign level = on ? prod : 16'd0;

endmodule

[sv/rgbled_checker.sv]
// rgbled_checker: port-level assertions for rgb_led_effect_controller_unit,
// attached by the bind at the end of this file
// depends on rgbled_pkg and the top level's ports
module rgbled_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_red_level,
  input logic [15:0] out_green_level,
  input logic [15:0] out_blue_level,
  input logic [1:0]  out_power_mode
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red_level)
      && $stable(out_green_level) && $stable(out_blue_level) && $stable(out_power_mode))
    else $error("stalled result changed");

  // each new result follows an accepted request transaction
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without request");

  // dark unless powered on
  a_dark_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_power_mode != rgbled_pkg::MODE_ON |->
      out_red_level == 16'd0 && out_green_level == 16'd0 && out_blue_level == 16'd0)
    else $error("light while not on");

  // gamma times brightness never exceeds 255 * 255, and the mode code is never 3
  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_red_level <= 16'd65025 && out_green_level <= 16'd65025
      && out_blue_level <= 16'd65025 && out_power_mode != 2'd3)
    else $error("level or mode out of range");

endmodule

bind rgb_led_effect_controller_unit rgbled_checker u_rgbled_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_red_level   (out_red_level),
  .out_green_level (out_green_level),
  .out_blue_level  (out_blue_level),
  .out_power_mode  (out_power_mode)
);
